FILE: rtl/core/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
package spq_pkg;

  // Fixed field widths
  localparam int unsigned ValueW = 32;
  localparam int unsigned RankW  = 4;
  localparam int unsigned OpW    = 2;
  localparam int unsigned CountW = 5;

  // Operation codes
  typedef enum logic [OpW-1:0] {
    OpInsert = 2'd0,
    OpRemMax = 2'd1,
    OpRemAt  = 2'd2,
    OpNone   = 2'd3
  } spq_op_e;

  // Broadcast control to every cell for the current item
  typedef struct packed {
    logic              ins;    // insert is being applied
    logic              rem;    // remove is being applied
    logic [RankW-1:0]  rank;   // first position that shifts on remove
    logic [ValueW-1:0] value;  // value to insert
  } spq_ctrl_t;

  // Data handed from one cell to the next one down the chain
  typedef struct packed {
    logic              keep;   // this cell holds a value >= the new one
    logic [ValueW-1:0] value;  // this cell's stored value
  } spq_link_t;

endpackage

FILE: rtl/core/spq_cell.sv
// One storage cell of the sorted chain: compare, hold or shift.
module spq_cell #(
  parameter int unsigned Idx = 0
) (
  input  logic                        clk_i,
  input  logic                        occupied_i,
  input  spq_pkg::spq_ctrl_t          ctrl_i,
  input  spq_pkg::spq_link_t          left_i,
  input  logic [spq_pkg::ValueW-1:0]  right_val_i,
  output spq_pkg::spq_link_t          link_o,
  output logic [spq_pkg::ValueW-1:0]  val_d_o
);

  localparam int unsigned RankMax = (1 << spq_pkg::RankW) - 1;
  localparam bit          IdxHi   = (Idx > RankMax);
  localparam logic [spq_pkg::RankW-1:0] IdxLo = spq_pkg::RankW'(Idx % (RankMax + 1));

  logic [spq_pkg::ValueW-1:0] val_q;
  logic [spq_pkg::ValueW-1:0] val_d;
  logic                       keep;
  logic                       shift;

  // Keep own value when it ranks ahead of the new one
  assign keep  = occupied_i && ($signed(val_q) >= $signed(ctrl_i.value));
  // Close the gap from the removed rank downward
  assign shift = IdxHi || (ctrl_i.rank <= IdxLo);

  // Select next value: hold, take new value, or take a neighbor's
  always_comb begin
    val_d = val_q;
    if (ctrl_i.ins) begin
      if (keep) begin
        val_d = val_q;
      end else if (left_i.keep) begin
        val_d = ctrl_i.value;
      end else begin
        val_d = left_i.value;
      end
    end else if (ctrl_i.rem && shift) begin
      val_d = right_val_i;
    end
  end

  // Payload register, no reset needed
  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign link_o.keep  = keep;
  assign link_o.value = val_q;
  assign val_d_o      = val_d;

endmodule

FILE: rtl/core/sorted_priority_queue_unit.sv
// Sorted priority queue built as a chain of compare-and-shift cells.
//
// Input channel (in_valid_i/in_ready_o) carries one operation per item:
// insert value_i, remove the largest entry, or remove the entry at rank_i.
// Output channel (out_valid_o/out_ready_i) returns one result item per
// operation: ok_o, count_o, largest_o, empty_res_o and full_res_o.
// Every cell compares against the broadcast value and moves its data to
// or from a neighbor in the same cycle, so one item is taken per cycle
// as long as the receiver takes each result. The result sits in the
// output register on the cycle after the item is accepted.
// A rejected operation (insert when full, remove when empty, rank at or
// beyond the count, undefined op) leaves the store unchanged, ok_o = 0.
// Reset clears the entry count and the output valid; the cell contents
// are not cleared and are never read before being written.
// When the receiver stalls, the held result blocks in_ready_o until it
// is taken, so no item is dropped.
module sorted_priority_queue_unit #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [spq_pkg::OpW-1:0]      op_i,
  input  logic signed [spq_pkg::ValueW-1:0] value_i,
  input  logic [spq_pkg::RankW-1:0]    rank_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic                         ok_o,
  output logic [spq_pkg::CountW-1:0]   count_o,
  output logic signed [spq_pkg::ValueW-1:0] largest_o,
  output logic                         empty_res_o,
  output logic                         full_res_o
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned RW = (CW > spq_pkg::RankW) ? CW : spq_pkg::RankW;
  localparam int unsigned XW = (CW > spq_pkg::CountW) ? CW : spq_pkg::CountW;
  localparam logic [CW-1:0] CapVal = CW'(CAPACITY);

  logic [CW-1:0]               count_q, count_d;
  logic                        accept;
  logic                        ok_d;
  spq_pkg::spq_op_e            op;
  spq_pkg::spq_ctrl_t          ctrl;
  logic [RW-1:0]               rank_x;
  logic [RW-1:0]               count_r;
  logic [XW-1:0]               count_x;
  logic [CAPACITY-1:0]         occupied;
  spq_pkg::spq_link_t          links [CAPACITY];
  logic [spq_pkg::ValueW-1:0]  vals_d [CAPACITY];

  assign in_ready_o = !out_valid_o || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign op         = spq_pkg::spq_op_e'(op_i);
  assign rank_x     = RW'(rank_i);
  assign count_r    = RW'(count_q);

  // Decide whether the operation applies and the new count
  always_comb begin
    ok_d    = 1'b0;
    count_d = count_q;
    unique case (op)
      spq_pkg::OpInsert: begin
        ok_d = (count_q != CapVal);
      end
      spq_pkg::OpRemMax: begin
        ok_d = (count_q != '0);
      end
      spq_pkg::OpRemAt: begin
        ok_d = (rank_x < count_r);
      end
      default: begin
        ok_d = 1'b0;
      end
    endcase
    if (accept && ok_d) begin
      if (op == spq_pkg::OpInsert) begin
        count_d = count_q + CW'(1);
      end else begin
        count_d = count_q - CW'(1);
      end
    end
  end

  // Broadcast control to the chain
  always_comb begin
    ctrl.ins   = accept && ok_d && (op == spq_pkg::OpInsert);
    ctrl.rem   = accept && ok_d && ((op == spq_pkg::OpRemMax) || (op == spq_pkg::OpRemAt));
    ctrl.rank  = (op == spq_pkg::OpRemAt) ? rank_i : '0;
    ctrl.value = value_i;
  end

  // Build the chain of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    spq_pkg::spq_link_t          left;
    logic [spq_pkg::ValueW-1:0]  right_val;

    assign occupied[i] = (CW'(i) < count_q);

    if (i == 0) begin : g_head
      assign left.keep  = 1'b1;
      assign left.value = value_i;
    end else begin : g_body
      assign left = links[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_val = links[i].value;
    end else begin : g_mid
      assign right_val = links[i+1].value;
    end

    spq_cell #(
      .Idx(i)
    ) u_cell (
      .clk_i       (clk_i),
      .occupied_i  (occupied[i]),
      .ctrl_i      (ctrl),
      .left_i      (left),
      .right_val_i (right_val),
      .link_o      (links[i]),
      .val_d_o     (vals_d[i])
    );
  end

  // Hold the entry count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  // Output register: load on accept, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (accept) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  assign count_x = XW'(count_d);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ok_o        <= ok_d;
      count_o     <= count_x[spq_pkg::CountW-1:0];
      largest_o   <= (count_d != '0) ? vals_d[0] : '0;
      empty_res_o <= (count_d == '0);
      full_res_o  <= (count_d == CapVal);
    end
  end

  // Checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CapVal)
    else $error("entry count exceeds capacity");

  a_reject_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !ok_d) |=> (count_q == $past(count_q)))
    else $error("rejected operation changed the count");

  for (genvar k = 0; k + 1 < CAPACITY; k++) begin : g_chk
    a_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
      (CW'(k + 1) < count_q) |-> ($signed(links[k].value) >= $signed(links[k+1].value)))
      else $error("stored entries out of order");
  end

endmodule

FILE: verif/spq_checker.sv
// Checker that predicts and compares every result item of the sorted priority queue.
module spq_checker
  import spq_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic                     in_ready_i,
  input  logic [OpW-1:0]           op_i,
  input  logic signed [ValueW-1:0] value_i,
  input  logic [RankW-1:0]         rank_i,
  input  logic                     out_valid_i,
  input  logic                     out_ready_i,
  input  logic                     ok_i,
  input  logic [CountW-1:0]        count_i,
  input  logic signed [ValueW-1:0] largest_i,
  input  logic                     empty_res_i,
  input  logic                     full_res_i,
  output int                       mismatches_o,
  output int                       pending_o,
  output int                       checked_o,
  output int                       rejected_o,
  output int                       full_hits_o,
  output int                       empty_hits_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic                     ok;
    logic [CountW-1:0]        count;
    logic signed [ValueW-1:0] largest;
    logic                     empty;
    logic                     full;
  } queue_status_t;

  // Shadow store, kept in descending order like the cell chain
  logic signed [ValueW-1:0] prio_vals [CAPACITY];
  int unsigned              prio_cnt;
  queue_status_t            expected_status [$];
  int n_mismatch, n_checked, n_rejected, n_full, n_empty;

  // Apply one operation to the shadow store and return the status it yields
  task automatic apply_queue_op(input spq_op_e kind, input logic signed [ValueW-1:0] val,
                                input logic [RankW-1:0] at_rank, output queue_status_t st);
    int unsigned pos;
    int unsigned at;
    int unsigned i;
    logic        done;
    done = 1'b0;
    at   = 0;
    case (kind)
      OpInsert: begin
        if (prio_cnt < CAPACITY) begin
          // Move smaller entries down; equal ones stay ahead of the new value
          pos = prio_cnt;
          while (pos > 0 && val > prio_vals[pos-1]) begin
            prio_vals[pos] = prio_vals[pos-1];
            pos--;
          end
          prio_vals[pos] = val;
          prio_cnt++;
          done = 1'b1;
        end
      end
      OpRemMax, OpRemAt: begin
        if (kind == OpRemAt) at = at_rank;
        if (at < prio_cnt) begin
          // Close the gap left by the removed entry
          for (i = at; i + 1 < prio_cnt; i++) prio_vals[i] = prio_vals[i+1];
          prio_cnt--;
          done = 1'b1;
        end
      end
      default: ;
    endcase
    st.ok      = done;
    st.count   = prio_cnt[CountW-1:0];
    st.largest = (prio_cnt > 0) ? prio_vals[0] : '0;
    st.empty   = (prio_cnt == 0);
    st.full    = (prio_cnt == CAPACITY);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    queue_status_t want;
    queue_status_t got;
    if (!rst_ni) begin
      prio_cnt = 0;
      expected_status.delete();
    end else begin
      // Compare the result item taken at this edge with the oldest expectation
      if (out_valid_i && out_ready_i) begin
        got.ok      = ok_i;
        got.count   = count_i;
        got.largest = largest_i;
        got.empty   = empty_res_i;
        got.full    = full_res_i;
        if (expected_status.size() == 0) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("[%0t] unexpected result: ok=%0b count=%0d largest=%0d empty=%0b full=%0b",
                     $realtime, got.ok, got.count, got.largest, got.empty, got.full);
        end else begin
          want = expected_status.pop_front();
          n_checked++;
          if (got.ok !== want.ok || got.count !== want.count ||
              got.largest !== want.largest || got.empty !== want.empty ||
              got.full !== want.full) begin
            n_mismatch++;
            if (n_mismatch <= 10)
              $display("[%0t] result %0d: expected ok=%0b count=%0d largest=%0d empty=%0b full=%0b",
                       $realtime, n_checked, want.ok, want.count, want.largest, want.empty,
                       want.full, "\n    got ok=%0b count=%0d largest=%0d empty=%0b full=%0b",
                       got.ok, got.count, got.largest, got.empty, got.full);
          end
        end
      end
      // Predict the result of the item taken at this edge
      if (in_valid_i && in_ready_i) begin
        apply_queue_op(spq_op_e'(op_i), value_i, rank_i, want);
        if (!want.ok) n_rejected++;
        if (want.full) n_full++;
        if (want.empty) n_empty++;
        expected_status.push_back(want);
      end
    end
    mismatches_o <= n_mismatch;
    pending_o    <= expected_status.size();
    checked_o    <= n_checked;
    rejected_o   <= n_rejected;
    full_hits_o  <= n_full;
    empty_hits_o <= n_empty;
  end

endmodule

FILE: verif/tb_sorted_priority_queue_unit.sv
// Testbench top: drives operations into the sorted priority queue and reports the verdict.
module tb_sorted_priority_queue_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import spq_pkg::*;

  localparam int unsigned Capacity  = 16;
  localparam int unsigned NumRandom = 2000;

  typedef enum int {ReadyAlways, ReadyHalf, ReadyQuarter, ReadyRare} ready_mode_e;

  logic                     clk      = 1'b0;
  logic                     rst_n    = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [OpW-1:0]           op       = OpNone;
  logic signed [ValueW-1:0] value    = '0;
  logic [RankW-1:0]         rank     = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic                     ok;
  logic [CountW-1:0]        count;
  logic signed [ValueW-1:0] largest;
  logic                     empty_res;
  logic                     full_res;

  int mismatches, pending, checked, rejected, full_hits, empty_hits;
  int unsigned n_sent;
  ready_mode_e ready_mode = ReadyAlways;
  int unsigned ready_left = 0;

  sorted_priority_queue_unit #(
    .CAPACITY(Capacity)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .op_i       (op),
    .value_i    (value),
    .rank_i     (rank),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .ok_o       (ok),
    .count_o    (count),
    .largest_o  (largest),
    .empty_res_o(empty_res),
    .full_res_o (full_res)
  );

  spq_checker #(
    .CAPACITY(Capacity)
  ) u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .op_i        (op),
    .value_i     (value),
    .rank_i      (rank),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .ok_i        (ok),
    .count_i     (count),
    .largest_i   (largest),
    .empty_res_i (empty_res),
    .full_res_i  (full_res),
    .mismatches_o(mismatches),
    .pending_o   (pending),
    .checked_o   (checked),
    .rejected_o  (rejected),
    .full_hits_o (full_hits),
    .empty_hits_o(empty_hits)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Stall the result side in stretches, each with its own ready density
  always @(posedge clk) begin
    if (ready_left == 0) begin
      ready_mode <= ready_mode_e'($urandom_range(0, 3));
      ready_left <= $urandom_range(20, 200);
    end else begin
      ready_left <= ready_left - 1;
    end
    case (ready_mode)
      ReadyAlways:  out_ready <= 1'b1;
      ReadyHalf:    out_ready <= ($urandom_range(0, 1) == 0);
      ReadyQuarter: out_ready <= ($urandom_range(0, 3) == 0);
      default:      out_ready <= (ready_left[3:0] == 4'd0);
    endcase
  end

  // Present one item and hold it until the block takes it
  task automatic send_op(input logic [OpW-1:0] o, input logic signed [ValueW-1:0] v,
                         input logic [RankW-1:0] r);
    in_valid <= 1'b1;
    op       <= o;
    value    <= v;
    rank     <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_sent++;
  endtask

  // Wait until every predicted result has been taken
  task automatic drain_results();
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Mix full-range values with a narrow band for ties and the extremes
  function automatic logic signed [ValueW-1:0] pick_value();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 4) return $urandom;
    if (sel < 8) return $signed($urandom_range(0, 16)) - 8;
    case ($urandom_range(0, 3))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return '0;
      default: return '1;
    endcase
  endfunction

  initial begin
    logic [OpW-1:0]           pick_op;
    logic signed [ValueW-1:0] pick_val;
    logic [RankW-1:0]         pick_rank;
    int unsigned              burst_left;
    int unsigned              phase_left;
    int unsigned              roll;
    int unsigned              n_directed;
    int unsigned              n;
    bit                       filling;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty store: removes are rejected, and so is the undefined op
    send_op(OpRemMax, '0, '0);
    send_op(OpRemAt, '1, '0);
    send_op(OpNone, 32'h5A5A_A5A5, 4'hF);

    // Extremes and ties
    send_op(OpInsert, 32'h8000_0000, 4'hF);
    send_op(OpInsert, 32'h7FFF_FFFF, '0);
    send_op(OpInsert, '0, '0);
    send_op(OpInsert, '1, '0);
    send_op(OpInsert, 32'sd5, '0);
    send_op(OpInsert, 32'sd5, '0);

    // Ranks beyond and at the count, then valid removes
    send_op(OpRemAt, 32'h1234_5678, 4'hF);
    send_op(OpRemAt, '0, 4'd6);
    send_op(OpRemAt, '0, 4'd2);
    send_op(OpRemMax, '0, '0);

    // Fill up, insert into the full store, then remove the last rank
    while (n_sent < 25) send_op(OpInsert, $signed($urandom_range(0, 6)) - 3, '0);
    send_op(OpInsert, 32'sd100, '0);
    send_op(OpRemAt, '0, 4'hF);
    send_op(OpRemMax, '0, '0);
    n_directed = n_sent;

    in_valid <= 1'b0;
    drain_results();

    // Random part: alternate insert-heavy and remove-heavy phases
    filling    = 1'b1;
    phase_left = $urandom_range(10, 60);
    burst_left = $urandom_range(1, 40);
    for (n = 0; n < NumRandom; n++) begin
      if (phase_left == 0) begin
        filling    = !filling;
        phase_left = $urandom_range(10, 60);
      end
      phase_left--;
      roll      = $urandom_range(0, 99);
      pick_val  = pick_value();
      pick_rank = $urandom_range(0, 15);
      if (roll < (filling ? 65 : 25))      pick_op = OpInsert;
      else if (roll < (filling ? 80 : 55)) pick_op = OpRemMax;
      else if (roll < 97)                  pick_op = OpRemAt;
      else                                 pick_op = OpNone;

      // Idle between bursts; now and then hold off until all results are back
      if (burst_left == 0) begin
        in_valid <= 1'b0;
        if ($urandom_range(0, 19) == 0) drain_results();
        else repeat ($urandom_range(1, 8)) @(posedge clk);
        burst_left = $urandom_range(1, 40);
      end
      burst_left--;
      send_op(pick_op, pick_val, pick_rank);
    end

    in_valid <= 1'b0;
    drain_results();
    repeat (4) @(posedge clk);

    $display("Sent %0d operations (%0d directed), random bursts with result-side stalls.",
             n_sent, n_directed);
    $display("Checked %0d results: %0d rejected, store full %0d times, empty %0d times.",
             checked, rejected, full_hits, empty_hits);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Stop a hung run; well above the slowest correct run
  initial begin
    #3_000_000;
    $display("timeout with %0d results outstanding", pending);
    $display("CHECK FAILED");
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/spq_pkg.sv
rtl/core/spq_cell.sv
rtl/core/sorted_priority_queue_unit.sv
verif/spq_checker.sv
verif/tb_sorted_priority_queue_unit.sv
